/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/swq_pkg.sv */
// ---------------------------------------------------------------------------
// swq_pkg
// Types and codes of the sorted wakeup event queue.
// ---------------------------------------------------------------------------
package swq_pkg;

   // request function codes
   localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [1:0] FUNC_CANCEL   = 2'd1;
   localparam logic [1:0] FUNC_TICK     = 2'd2;
   localparam logic [1:0] FUNC_NONE     = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_SCHED   = 2'd0;
   localparam logic [1:0] KIND_CANCEL  = 2'd1;
   localparam logic [1:0] KIND_EXPIRED = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] wake_time;
      logic [31:0] now_time;
      logic [31:0] target_id;
      logic [15:0] handler_tag;
      logic        has_handler;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        ok;
      logic        found;
      logic [31:0] wake_id;
      logic [15:0] out_tag;
      logic        out_has_handler;
      logic [31:0] next_deadline;
      logic        deadline_valid;
      logic        last;
   } rsp_type;

   // one queue slot: tag bit 16 is the handler flag
   typedef struct packed {
      logic [31:0] deadline;
      logic [31:0] id;
      logic [16:0] tag;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCH_CHK,
      ST_SCH_CMP,
      ST_SCH_PUT,
      ST_CAN_CHK,
      ST_CAN_CMP,
      ST_CAN_SHF,
      ST_CAN_MOV,
      ST_TCK_CHK,
      ST_TCK_CMP,
      ST_HEAD_RD,
      ST_HEAD_LAT,
      ST_EMIT,
      ST_SEND
   } ctl_state_type;

   typedef enum logic [2:0] {
      RD_HEAD,
      RD_IDX,
      RD_IDX_DEC,
      RD_IDX_INC,
      RD_EMIT,
      RD_EMIT_INC
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      rd_sel_type rd_sel;
      logic       wr_move;
      logic       wr_new;
      logic       idx_inc;
      logic       idx_dec;
      logic       head_inc;
      logic       tail_inc;
      logic       tail_dec;
      logic       cnt_inc;
      logic       emit_step;
      logic       set_found;
      logic       set_sch_ok;
      logic       latch_nd;
      logic       rsp_load;
      logic [1:0] rsp_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] in_func;
      logic [1:0] cur_func;
      logic       full;
      logic       empty;
      logic       idx_eq_head;
      logic       idx_eq_tail;
      logic       nx_eq_tail;
      logic       count_max;
      logic       count_zero;
      logic       count_one;
      logic       dl_le_wake;
      logic       dl_le_now;
      logic       id_match;
   } sts_type;

endpackage

/* src/swq_controller.sv */
// ---------------------------------------------------------------------------
// swq_controller
// Sequencer for schedule, cancel and tick walks over the queue memory.
// ---------------------------------------------------------------------------
module swq_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  swq_pkg::sts_type sts,
   output logic             busy,
   output swq_pkg::cmd_type cmd
);
   import swq_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (sts.in_func)
                  FUNC_SCHEDULE: state_in = sts.full ? ST_HEAD_RD : ST_SCH_CHK;
                  FUNC_CANCEL:   state_in = ST_CAN_CHK;
                  FUNC_TICK:     state_in = ST_TCK_CHK;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCH_CHK: state_in = sts.idx_eq_head ? ST_SCH_PUT : ST_SCH_CMP;
         ST_SCH_CMP: state_in = sts.dl_le_wake ? ST_SCH_PUT : ST_SCH_CHK;
         ST_SCH_PUT: state_in = ST_HEAD_RD;
         ST_CAN_CHK: state_in = sts.idx_eq_tail ? ST_HEAD_RD : ST_CAN_CMP;
         ST_CAN_CMP: state_in = sts.id_match ? ST_CAN_SHF : ST_CAN_CHK;
         ST_CAN_SHF: state_in = sts.nx_eq_tail ? ST_HEAD_RD : ST_CAN_MOV;
         ST_CAN_MOV: state_in = ST_CAN_SHF;
         ST_TCK_CHK: state_in = (sts.empty || sts.count_max) ? ST_HEAD_RD : ST_TCK_CMP;
         ST_TCK_CMP: state_in = sts.dl_le_now ? ST_TCK_CHK : ST_HEAD_RD;
         ST_HEAD_RD: state_in = ST_HEAD_LAT;
         ST_HEAD_LAT: begin
            if (sts.cur_func == FUNC_TICK && !sts.count_zero) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_EMIT: state_in = sts.count_one ? ST_SEND : ST_EMIT;
         ST_SEND: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_HEAD;
      busy       = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = start && (sts.in_func != FUNC_NONE);
         end
         ST_SCH_CHK: begin
            cmd.rd_sel = RD_IDX_DEC;
         end
         ST_SCH_CMP: begin
            if (!sts.dl_le_wake) begin
               cmd.wr_move = 1'b1;
               cmd.idx_dec = 1'b1;
            end
         end
         ST_SCH_PUT: begin
            cmd.wr_new     = 1'b1;
            cmd.tail_inc   = 1'b1;
            cmd.set_sch_ok = 1'b1;
         end
         ST_CAN_CHK: begin
            cmd.rd_sel = RD_IDX;
         end
         ST_CAN_CMP: begin
            if (sts.id_match) begin
               cmd.set_found = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_CAN_SHF: begin
            cmd.rd_sel   = RD_IDX_INC;
            cmd.tail_dec = sts.nx_eq_tail;
         end
         ST_CAN_MOV: begin
            cmd.wr_move = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         ST_TCK_CHK: begin
            cmd.rd_sel = RD_HEAD;
         end
         ST_TCK_CMP: begin
            cmd.head_inc = sts.dl_le_now;
            cmd.cnt_inc  = sts.dl_le_now;
         end
         ST_HEAD_RD: begin
            cmd.rd_sel = RD_HEAD;
         end
         ST_HEAD_LAT: begin
            cmd.latch_nd = 1'b1;
            cmd.rd_sel   = RD_EMIT;
         end
         ST_EMIT: begin
            cmd.rsp_load  = 1'b1;
            cmd.rsp_kind  = KIND_EXPIRED;
            cmd.emit_step = 1'b1;
            cmd.rd_sel    = RD_EMIT_INC;
         end
         ST_SEND: begin
            cmd.rsp_load = 1'b1;
            unique case (sts.cur_func)
               FUNC_SCHEDULE: cmd.rsp_kind = KIND_SCHED;
               FUNC_CANCEL:   cmd.rsp_kind = KIND_CANCEL;
               default:       cmd.rsp_kind = KIND_DONE;
            endcase
         end
         default: begin
            cmd.rd_sel = RD_HEAD;
         end
      endcase
   end

endmodule

/* src/swq_datapath.sv */
// ---------------------------------------------------------------------------
// swq_datapath
// Queue memory, ring pointers, id counter and result register.
// ---------------------------------------------------------------------------
module swq_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  swq_pkg::cmd_type cmd,
   input  swq_pkg::req_type req_data,
   output swq_pkg::sts_type sts,
   output logic             rsp_strobe,
   output swq_pkg::rsp_type rsp_data
);
   import swq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [PTR_W-1:0] ptr_type;

   localparam ptr_type PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   function automatic ptr_type ptr_inc(input ptr_type p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      return (p == '0) ? PTR_LAST : p - PTR_W'(1);
   endfunction

   entry_type   entry_mem_ff [QUEUE_DEPTH];
   entry_type   rd_data_ff;
   entry_type   new_entry;
   ptr_type     rd_addr;

   ptr_type     head_ff, head_in;
   ptr_type     tail_ff, tail_in;
   ptr_type     idx_ff, idx_in;
   ptr_type     emit_ff, emit_in;
   ptr_type     count_ff, count_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] id_plus;
   req_type     req_ff;
   logic        sch_ok_ff;
   logic        found_ff;
   logic [31:0] nd_ff;
   logic        dvalid_ff;
   logic        rsp_strobe_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        empty;

   assign empty   = (head_ff == tail_ff);
   assign id_plus = id_ff + 32'd1;

   always_comb begin
      new_entry.deadline = req_ff.wake_time;
      new_entry.id       = id_ff;
      new_entry.tag      = req_ff.has_handler ? {1'b1, req_ff.handler_tag} : '0;
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:      rd_addr = idx_ff;
         RD_IDX_DEC:  rd_addr = ptr_dec(idx_ff);
         RD_IDX_INC:  rd_addr = ptr_inc(idx_ff);
         RD_EMIT:     rd_addr = emit_ff;
         RD_EMIT_INC: rd_addr = ptr_inc(emit_ff);
         default:     rd_addr = head_ff;
      endcase
   end

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_move) begin
         entry_mem_ff[idx_ff] <= rd_data_ff;
      end else if (cmd.wr_new) begin
         entry_mem_ff[idx_ff] <= new_entry;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   // pointer and counter next values
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      idx_in   = idx_ff;
      emit_in  = emit_ff;
      count_in = count_ff;
      id_in    = id_ff;
      if (cmd.accept) begin
         emit_in  = head_ff;
         count_in = '0;
         if (req_data.func == FUNC_SCHEDULE) begin
            idx_in = tail_ff;
            id_in  = (id_plus == '0) ? 32'd1 : id_plus;  // id zero is never issued
         end else begin
            idx_in = head_ff;
         end
      end
      if (cmd.idx_inc)   idx_in   = ptr_inc(idx_ff);
      if (cmd.idx_dec)   idx_in   = ptr_dec(idx_ff);
      if (cmd.head_inc)  head_in  = ptr_inc(head_ff);
      if (cmd.tail_inc)  tail_in  = ptr_inc(tail_ff);
      if (cmd.tail_dec)  tail_in  = ptr_dec(tail_ff);
      if (cmd.cnt_inc)   count_in = count_ff + PTR_W'(1);
      if (cmd.emit_step) begin
         emit_in  = ptr_inc(emit_ff);
         count_in = count_ff - PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         id_ff         <= '0;
         idx_ff        <= '0;
         emit_ff       <= '0;
         count_ff      <= '0;
         sch_ok_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         id_ff         <= id_in;
         idx_ff        <= idx_in;
         emit_ff       <= emit_in;
         count_ff      <= count_in;
         sch_ok_ff     <= cmd.accept ? 1'b0 : (sch_ok_ff | cmd.set_sch_ok);
         found_ff      <= cmd.accept ? 1'b0 : (found_ff | cmd.set_found);
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   // request and head deadline capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.latch_nd) begin
         dvalid_ff <= !empty;
         nd_ff     <= empty ? 32'd0 : rd_data_ff.deadline;
      end
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.kind           = cmd.rsp_kind;
      rsp_in.next_deadline  = nd_ff;
      rsp_in.deadline_valid = dvalid_ff;
      rsp_in.last           = (cmd.rsp_kind != KIND_EXPIRED);
      case (cmd.rsp_kind)
         KIND_SCHED: begin
            rsp_in.ok      = sch_ok_ff;
            rsp_in.wake_id = sch_ok_ff ? id_ff : 32'd0;
         end
         KIND_CANCEL: begin
            rsp_in.ok    = !empty;
            rsp_in.found = found_ff;
         end
         KIND_EXPIRED: begin
            rsp_in.wake_id         = rd_data_ff.id;
            rsp_in.out_tag         = rd_data_ff.tag[15:0];
            rsp_in.out_has_handler = rd_data_ff.tag[16];
         end
         default: begin
            rsp_in.ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      sts.in_func     = req_data.func;
      sts.cur_func    = req_ff.func;
      sts.full        = (ptr_inc(tail_ff) == head_ff);
      sts.empty       = empty;
      sts.idx_eq_head = (idx_ff == head_ff);
      sts.idx_eq_tail = (idx_ff == tail_ff);
      sts.nx_eq_tail  = (ptr_inc(idx_ff) == tail_ff);
      sts.count_max   = (count_ff == PTR_LAST);
      sts.count_zero  = (count_ff == '0);
      sts.count_one   = (count_ff == PTR_W'(1));
      sts.dl_le_wake  = (rd_data_ff.deadline <= req_ff.wake_time);
      sts.dl_le_now   = (rd_data_ff.deadline <= req_ff.now_time);
      sts.id_match    = (rd_data_ff.id == req_ff.target_id);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* src/sorted_wakeup_event_queue_unit.sv */
// ---------------------------------------------------------------------------
// sorted_wakeup_event_queue_unit
// Deadline-ordered wakeup queue with schedule, cancel and tick requests.
// ---------------------------------------------------------------------------
//
//  channel   ports                          transfer when
//  -------   ----------------------------   ------------------------------
//  request   start, busy, req_data          start high and busy low
//  result    rsp_strobe, rsp_data           every cycle rsp_strobe is high
//
//  Busy lasts while the request walks the queue memory, which has one
//  port and registered read data: a schedule walks the entries it moves
//  unless the queue is full, a cancel walks the queued entries and a tick
//  walks and then reports the expired events. The final strobe follows the
//  last busy cycle. Reset clears the pointers, counters, flags, strobe and
//  controller state, not the queue memory. Results cannot stall.
//
module sorted_wakeup_event_queue_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  swq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output swq_pkg::rsp_type rsp_data
);
   import swq_pkg::*;

   `include "assert_macros.svh"

   cmd_type cmd;   // controller commands
   sts_type sts;   // datapath status

   // sequencer: one request at a time
   swq_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   // queue memory, ring pointers, id counter, result register
   swq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // a real request always makes the unit busy next cycle
   `ASSERT_NEXT(a_start_busy, start && !busy && req_data.func != FUNC_NONE, busy)
   // the final result of a request is never directly followed by another
   `ASSERT_NEXT(a_last_gap, rsp_strobe && rsp_data.last, !rsp_strobe)
   // only expired events are non-final
   `ASSERT_SAME(a_nonlast_kind, rsp_strobe && !rsp_data.last, rsp_data.kind == KIND_EXPIRED)
   // empty queue reports a zero deadline
   `ASSERT_SAME(a_empty_dl, rsp_strobe && !rsp_data.deadline_valid,
                rsp_data.next_deadline == 32'd0)

endmodule

/* dv/tb_sorted_wakeup_event_queue_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sorted_wakeup_event_queue_unit
// Self-checking bench for the sorted wakeup event queue. A directed opening
// covers the empty and full queue, equal deadlines, unknown ids and the unused
// function code. Random schedule/cancel/tick traffic follows. A behavioral
// queue model predicts every result, and a monitor checks each field of each
// result strobe in order.
// ---------------------------------------------------------------------------
module tb_sorted_wakeup_event_queue_unit;
   import swq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int RANDOM_OPS  = 315;
   localparam int CYCLE_LIMIT = 200000;  // watchdog limit, well above the slowest legal run
   localparam int DRAIN_WAIT  = 100;     // quiet tail, longer than the longest request walk

   // wake times for the directed fill; equal deadlines, both extremes, mixed order
   localparam logic [15*32-1:0] FILL_WAKE = {
      32'hFFFF_FFFF, 32'd0,   32'd100, 32'd100, 32'd100,
      32'd50,        32'd200, 32'd100, 32'd7,   32'd300,
      32'd100,       32'hFFFF_FFFF,    32'd150, 32'd0,   32'd250};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   sorted_wakeup_event_queue_unit #(
      .QUEUE_DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // requests waiting to be driven, and replies the model says are still due
   req_type request_backlog[$];
   rsp_type expected_replies[$];

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_left   = 0;
   bit          no_idle     = 1'b0;

   // ------------------------------------------------------------------------
   // Queue model: circular slot store, head..tail kept in deadline order
   // ------------------------------------------------------------------------
   entry_type   model_slot[DEPTH];
   int unsigned model_head    = 0;
   int unsigned model_tail    = 0;
   logic [31:0] model_next_id = '0;

   // every reply carries the head deadline as it stands after the request
   function automatic rsp_type make_reply(input logic [1:0] kind, input logic ok,
                                          input logic found, input logic [31:0] id,
                                          input logic [15:0] tag, input logic hh,
                                          input logic last);
      rsp_type rsp;
      rsp.kind            = kind;
      rsp.ok              = ok;
      rsp.found           = found;
      rsp.wake_id         = id;
      rsp.out_tag         = tag;
      rsp.out_has_handler = hh;
      rsp.deadline_valid  = (model_head != model_tail);
      rsp.next_deadline   = rsp.deadline_valid ? model_slot[model_head].deadline : 32'd0;
      rsp.last            = last;
      return rsp;
   endfunction

   // advance the model by one accepted request and queue the replies it owes
   task automatic apply_request(input req_type r);
      int unsigned idx;
      int unsigned nxt;
      int unsigned n;
      bit          hit;
      entry_type   gone[DEPTH];
      case (r.func)
         FUNC_SCHEDULE: begin
            // id advances even on a rejected schedule and skips zero on wrap
            model_next_id = model_next_id + 32'd1;
            if (model_next_id == 32'd0) model_next_id = 32'd1;
            nxt = (model_tail + 1) % DEPTH;
            if (nxt == model_head) begin
               expected_replies.push_back(
                  make_reply(KIND_SCHED, 1'b0, 1'b0, 32'd0, 16'd0, 1'b0, 1'b1));
            end else begin
               // shift later deadlines up; equal deadlines stay ahead of the new one
               idx = model_tail;
               hit = 1'b0;
               while (idx != model_head && !hit) begin
                  n = (idx + DEPTH - 1) % DEPTH;
                  if (model_slot[n].deadline <= r.wake_time) begin
                     hit = 1'b1;
                  end else begin
                     model_slot[idx] = model_slot[n];
                     idx = n;
                  end
               end
               model_slot[idx].deadline = r.wake_time;
               model_slot[idx].id       = model_next_id;
               model_slot[idx].tag      = r.has_handler ? {1'b1, r.handler_tag} : 17'd0;
               model_tail = nxt;
               expected_replies.push_back(
                  make_reply(KIND_SCHED, 1'b1, 1'b0, model_next_id, 16'd0, 1'b0, 1'b1));
            end
         end
         FUNC_CANCEL: begin
            // first match from the head only; the rest close the gap
            idx = model_head;
            hit = 1'b0;
            while (idx != model_tail && !hit) begin
               if (model_slot[idx].id == r.target_id) hit = 1'b1;
               else idx = (idx + 1) % DEPTH;
            end
            if (hit) begin
               nxt = (idx + 1) % DEPTH;
               while (nxt != model_tail) begin
                  model_slot[idx] = model_slot[nxt];
                  idx = nxt;
                  nxt = (nxt + 1) % DEPTH;
               end
               model_tail = (model_tail + DEPTH - 1) % DEPTH;
            end
            expected_replies.push_back(
               make_reply(KIND_CANCEL, model_head != model_tail, hit, 32'd0, 16'd0,
                          1'b0, 1'b1));
         end
         FUNC_TICK: begin
            // pop every due event first so all replies see the final head
            n = 0;
            while (model_head != model_tail && n < DEPTH - 1 &&
                   model_slot[model_head].deadline <= r.now_time) begin
               gone[n] = model_slot[model_head];
               n++;
               model_head = (model_head + 1) % DEPTH;
            end
            for (idx = 0; idx < n; idx++)
               expected_replies.push_back(make_reply(KIND_EXPIRED, 1'b0, 1'b0, gone[idx].id,
                                          gone[idx].tag[15:0], gone[idx].tag[16], 1'b0));
            expected_replies.push_back(
               make_reply(KIND_DONE, 1'b0, 1'b0, 32'd0, 16'd0, 1'b0, 1'b1));
         end
         default: ;  // unused code: no reply, no state change
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // fields not used by the function stay random, so every bit toggles
   task automatic push_request(input logic [1:0] func, input logic [31:0] wake,
                               input logic [31:0] now, input logic [31:0] target,
                               input logic [31:0] tag, input logic [31:0] hh);
      req_type r;
      r.func        = func;
      r.wake_time   = wake;
      r.now_time    = now;
      r.target_id   = target;
      r.handler_tag = tag[15:0];
      r.has_handler = hh[0];
      request_backlog.push_back(r);
   endtask

   // ------------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Request driver: a transfer happens at an edge with start high and busy
   // low. The model is advanced at that same edge. Between transfers the
   // driver may idle, with occasional stretches of back-to-back requests.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      int unsigned gap;
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else if (start) begin
         if (!busy) begin
            apply_request(req_data);
            if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (gap == 0 && request_backlog.size() != 0) begin
               // keep start high for the next transfer
               req_data <= request_backlog.pop_front();
            end else begin
               start     <= 1'b0;
               idle_left <= (gap == 0) ? 0 : gap - 1;
            end
         end
      end else if (idle_left != 0) begin
         idle_left <= idle_left - 1;
      end else if (request_backlog.size() != 0) begin
         req_data <= request_backlog.pop_front();
         start    <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: each strobe is one transfer, checked against the oldest
   // expected reply
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            $error("result with nothing expected: kind %0d id %0h",
                   rsp_data.kind, rsp_data.wake_id);
            fail_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
            check_field("ok", 32'(want.ok), 32'(rsp_data.ok));
            check_field("found", 32'(want.found), 32'(rsp_data.found));
            check_field("wake_id", want.wake_id, rsp_data.wake_id);
            check_field("out_tag", 32'(want.out_tag), 32'(rsp_data.out_tag));
            check_field("out_has_handler", 32'(want.out_has_handler),
                        32'(rsp_data.out_has_handler));
            check_field("next_deadline", want.next_deadline, rsp_data.next_deadline);
            check_field("deadline_valid", 32'(want.deadline_valid),
                        32'(rsp_data.deadline_valid));
            check_field("last", 32'(want.last), 32'(rsp_data.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int unsigned i;
      int unsigned placed;
      int unsigned pick;
      int unsigned issued;
      int unsigned t_base;
      logic [31:0] last_wake;
      bit          filling;
      req_type     r;
      logic [127:0] rnd;

      // empty queue: tick gives only the done reply, cancel finds nothing
      push_request(FUNC_TICK, $urandom, 32'd0, $urandom, $urandom, $urandom);
      push_request(FUNC_CANCEL, $urandom, $urandom, 32'd1, $urandom, $urandom);
      // fill to capacity; first two carry the tag extremes, a later one has a
      // tag but no handler so its tag must come back as zero
      push_request(FUNC_SCHEDULE, FILL_WAKE[0 +: 32], $urandom, $urandom,
                   32'h0000_FFFF, 32'd1);
      push_request(FUNC_SCHEDULE, FILL_WAKE[32 +: 32], $urandom, $urandom,
                   32'h0000_0000, 32'd0);
      push_request(FUNC_SCHEDULE, FILL_WAKE[64 +: 32], $urandom, $urandom,
                   32'h0000_A5A5, 32'd0);
      for (i = 3; i < 15; i++)
         push_request(FUNC_SCHEDULE, FILL_WAKE[i*32 +: 32], $urandom, $urandom,
                      $urandom, $urandom);
      // full queue: rejected, but id 16 is consumed
      push_request(FUNC_SCHEDULE, 32'd1, $urandom, $urandom, $urandom, 32'd1);
      // cancel from the middle, then ids that never existed
      push_request(FUNC_CANCEL, $urandom, $urandom, 32'd5, $urandom, $urandom);
      push_request(FUNC_CANCEL, $urandom, $urandom, 32'hFFFF_FFFF, $urandom, $urandom);
      push_request(FUNC_CANCEL, $urandom, $urandom, 32'd0, $urandom, $urandom);
      push_request(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      // refill and drain a full queue in one tick: the longest reply burst
      push_request(FUNC_SCHEDULE, 32'd100, $urandom, $urandom, $urandom, 32'd1);
      push_request(FUNC_TICK, $urandom, 32'hFFFF_FFFF, $urandom, $urandom, $urandom);
      issued = 17;

      // random traffic in fill-leaning and drain-leaning phases; deadlines
      // mostly sit just ahead of a creeping time base so ticks expire some
      t_base    = $urandom;
      last_wake = t_base;
      filling   = 1'b1;
      placed    = 0;
      i         = 0;
      while (placed < RANDOM_OPS) begin
         if (i % 30 == 0) filling = $urandom_range(0, 1);
         i++;
         t_base += $urandom_range(0, 40);
         rnd  = {$urandom, $urandom, $urandom, $urandom};
         r    = rnd[$bits(req_type)-1:0];
         pick = $urandom_range(0, 99);
         if (pick < (filling ? 60 : 30)) begin
            r.func = FUNC_SCHEDULE;
            if ($urandom_range(0, 15) == 0) r.wake_time = $urandom;
            else if ($urandom_range(0, 7) == 0) r.wake_time = last_wake;
            else r.wake_time = t_base + $urandom_range(0, 400);
            last_wake = r.wake_time;
            issued++;
         end else if (pick < (filling ? 75 : 55)) begin
            r.func = FUNC_CANCEL;
            // mostly recent ids: some live, some already expired or cancelled
            if ($urandom_range(0, 7) != 0)
               r.target_id = issued - $urandom_range(0, (issued < 20) ? issued : 20);
         end else if (pick < 95) begin
            r.func = FUNC_TICK;
            if ($urandom_range(0, 15) != 0) r.now_time = t_base + $urandom_range(0, 100);
         end else begin
            r.func = FUNC_NONE;
         end
         if (r.func != FUNC_NONE) placed++;
         request_backlog.push_back(r);
      end

      // everything driven, every reply in, then a quiet tail for strays
      @(posedge clock);
      while (reset || start || request_backlog.size() != 0) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
